// ----- rtl/flow_counter_update_and_aging_defines.svh -----
// Assertion macros for the flow counter update and aging block.
`ifndef FLOW_COUNTER_UPDATE_AND_AGING_DEFINES_SVH
`define FLOW_COUNTER_UPDATE_AND_AGING_DEFINES_SVH
`ifndef SYNTH
`define FCA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define FCA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define FCA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FCA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/fca_pkg.sv -----
// Shared types and constants for the flow counter update and aging block.
`timescale 1ns / 1ps
`default_nettype none
package fca_pkg;
	typedef enum logic [1:0] {
		FUNC_ADD      = 2'd0,
		FUNC_SCAN     = 2'd1,
		FUNC_TEARDOWN = 2'd2,
		FUNC_BAD      = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ACT_NONE       = 3'd0,
		ACT_EXPORT     = 3'd1,
		ACT_DEL_EVICT  = 3'd2,
		ACT_DEL_AGED   = 3'd3,
		ACT_DEL_SHORT  = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		BK_IDLE  = 2'd0,
		BK_READ  = 2'd1,
		BK_EXEC  = 2'd2,
		BK_OUT   = 2'd3
	} bk_state_t;

	localparam logic [1:0] REG_AGE = 2'd0;
	localparam logic [1:0] REG_SYN = 2'd1;
	localparam logic [1:0] REG_SHORT = 2'd2;

	localparam logic [39:0] AGE_RESET = 40'd180000000;
	localparam logic [39:0] SYN_RESET = 40'd10000000;

	typedef struct packed {
		func_t        func;
		logic         idx_ok;
		logic [11:0]  flow_index;
		logic         kernel_valid;
		logic         evict_marked;
		logic [47:0]  kernel_bytes;
		logic [39:0]  kernel_packets;
		logic         is_tcp;
		logic         tcp_closed;
		logic         tcp_syn;
		logic         tcp_established;
		logic         short_flow;
		logic [63:0]  now_usec;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [48:0] byte_delta;
		logic [40:0] pkt_delta;
		logic [63:0] byte_sum;
		logic [63:0] pkt_sum;
		logic        first_export;
		logic        tcp_aged;
	} res_t;
endpackage
`default_nettype wire

// ----- rtl/fca_front.sv -----
// Input stage: accepts items, checks the index and queues commands.
`timescale 1ns / 1ps
`default_nettype none
module fca_front #(
	parameter int FLOW_ENTRIES = 4096
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [172:0]  in_data,
	output logic               q_valid,
	input  wire logic          q_ready,
	output fca_pkg::cmd_t      q_cmd
);
	localparam int DEPTH = 2;
	fca_pkg::cmd_t mem_q [DEPTH];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;
	fca_pkg::cmd_t c;
	logic          push, pop;

	always_comb begin
		c.func            = fca_pkg::func_t'(in_data[1:0]);
		c.flow_index      = in_data[13:2];
		c.idx_ok          = ({20'd0, in_data[13:2]} < 32'(FLOW_ENTRIES));
		c.kernel_valid    = in_data[14];
		c.evict_marked    = in_data[15];
		c.kernel_bytes    = in_data[63:16];
		c.kernel_packets  = in_data[103:64];
		c.is_tcp          = in_data[104];
		c.tcp_closed      = in_data[105];
		c.tcp_syn         = in_data[106];
		c.tcp_established = in_data[107];
		c.short_flow      = in_data[108];
		c.now_usec        = in_data[172:109];
	end

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_cmd    = mem_q[rp_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

// ----- rtl/fca_back.sv -----
// Execution stage: reads the flow entry, updates it and forms the result.
`timescale 1ns / 1ps
`default_nettype none
module fca_back #(
	parameter int FLOW_ENTRIES = 4096
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_valid,
	output logic               q_ready,
	input  wire fca_pkg::cmd_t q_cmd,
	input  wire logic [39:0]   age_interval,
	input  wire logic [39:0]   syn_age,
	input  wire logic          del_short,
	output logic               out_valid,
	input  wire logic          out_ready,
	output fca_pkg::res_t      out_res
);
	localparam int AW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;

	logic [63:0] bt_mem [FLOW_ENTRIES];
	logic [63:0] pt_mem [FLOW_ENTRIES];
	logic [63:0] lc_mem [FLOW_ENTRIES];
	logic [63:0] st_mem [FLOW_ENTRIES];
	logic        ex_mem [FLOW_ENTRIES];
	logic        td_mem [FLOW_ENTRIES];

	fca_pkg::bk_state_t state_q, state_d;
	fca_pkg::cmd_t      cmd_q;
	logic [63:0]        bt_q, pt_q, lc_q, st_q;
	logic               ex_q, td_q;
	fca_pkg::res_t      res_q, res_d;
	logic               wr_en;
	logic [63:0]        nbt, npt, nlc, nst;
	logic               nex, ntd;
	logic [AW-1:0]      addr;

	assign addr = AW'(cmd_q.flow_index);

	always_comb begin
		state_d = state_q;
		case (state_q)
			fca_pkg::BK_IDLE: if (q_valid) state_d = fca_pkg::BK_READ;
			fca_pkg::BK_READ: state_d = fca_pkg::BK_EXEC;
			fca_pkg::BK_EXEC: state_d = fca_pkg::BK_OUT;
			fca_pkg::BK_OUT:  if (out_ready) state_d = fca_pkg::BK_IDLE;
			default:          state_d = fca_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		q_ready   = (state_q == fca_pkg::BK_IDLE);
		out_valid = (state_q == fca_pkg::BK_OUT);
		wr_en     = (state_q == fca_pkg::BK_EXEC) && cmd_q.idx_ok;
	end

	always_comb begin
		logic        kv, fresh, deleted, bdiff, upd;
		logic [63:0] eb, ep;
		kv      = cmd_q.kernel_valid;
		nbt = bt_q; npt = pt_q; nlc = lc_q; nst = st_q; nex = ex_q; ntd = td_q;
		res_d   = '0;
		deleted = 1'b0;
		upd     = 1'b0;
		eb = {bt_q[63:48] + {15'd0, bt_q[47:0] > cmd_q.kernel_bytes}, cmd_q.kernel_bytes};
		ep = {pt_q[63:40] + {23'd0, pt_q[39:0] > cmd_q.kernel_packets},
			cmd_q.kernel_packets};
		bdiff = (bt_q[47:0] != cmd_q.kernel_bytes);
		fresh = kv && (bt_q[47:0] < cmd_q.kernel_bytes);
		if (cmd_q.func == fca_pkg::FUNC_ADD) begin
			nbt = '0; npt = '0; nlc = cmd_q.now_usec; nst = cmd_q.now_usec;
			nex = 1'b0; ntd = 1'b0;
		end else if (cmd_q.func == fca_pkg::FUNC_SCAN && !td_q) begin
			if (kv && cmd_q.is_tcp && (cmd_q.tcp_closed || (cmd_q.tcp_syn &&
				!cmd_q.tcp_established &&
				(cmd_q.now_usec - st_q) >= {24'd0, syn_age}))) begin
				res_d.tcp_aged = 1'b1;
			end
			if (kv && cmd_q.evict_marked) begin
				deleted = 1'b1;
				res_d.action = fca_pkg::ACT_DEL_EVICT;
			end else if (!fresh && (cmd_q.now_usec - lc_q) >= {24'd0, age_interval}) begin
				deleted = 1'b1;
				res_d.action = fca_pkg::ACT_DEL_AGED;
			end
			if (!deleted && kv) begin
				if (bdiff) begin
					upd = 1'b1;
					nlc = cmd_q.now_usec;
					res_d.first_export = !ex_q;
					nex = 1'b1;
					res_d.action = fca_pkg::ACT_EXPORT;
				end else if (!ex_q) begin
					res_d.first_export = 1'b1;
					nex = 1'b1;
					res_d.action = fca_pkg::ACT_EXPORT;
				end
			end
			if (!deleted && del_short && cmd_q.short_flow) begin
				res_d.action = fca_pkg::ACT_DEL_SHORT;
			end
		end else if (cmd_q.func == fca_pkg::FUNC_TEARDOWN && !td_q) begin
			upd = kv;
			res_d.first_export = !ex_q;
			nex = 1'b0;
			ntd = 1'b1;
			res_d.action = fca_pkg::ACT_EXPORT;
		end
		if (upd) begin
			nbt = eb;
			npt = ep;
			res_d.byte_delta = 49'(eb - bt_q);
			res_d.pkt_delta  = 41'(ep - pt_q);
		end
		res_d.byte_sum = nbt;
		res_d.pkt_sum  = npt;
		if (cmd_q.func == fca_pkg::FUNC_ADD || !cmd_q.idx_ok) begin
			res_d = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_valid && q_ready) begin
			cmd_q <= q_cmd;
		end
		if (state_q == fca_pkg::BK_READ) begin
			bt_q <= bt_mem[addr];
			pt_q <= pt_mem[addr];
			lc_q <= lc_mem[addr];
			st_q <= st_mem[addr];
			ex_q <= ex_mem[addr];
			td_q <= td_mem[addr];
		end
		if (wr_en) begin
			bt_mem[addr] <= nbt;
			pt_mem[addr] <= npt;
			lc_mem[addr] <= nlc;
			st_mem[addr] <= nst;
			ex_mem[addr] <= nex;
			td_mem[addr] <= ntd;
		end
		if (state_q == fca_pkg::BK_EXEC) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fca_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign out_res = res_q;
endmodule
`default_nettype wire

// ----- rtl/fca_regs.sv -----
// Configuration registers behind the APB-style port.
`timescale 1ns / 1ps
`default_nettype none
module fca_regs (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic [39:0]      age_interval,
	output logic [39:0]      syn_age,
	output logic             del_short
);
	logic [1:0] idx;
	logic       wr;
	assign idx = paddr[4:3];
	assign wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_interval <= fca_pkg::AGE_RESET;
			syn_age      <= fca_pkg::SYN_RESET;
			del_short    <= 1'b0;
		end else if (wr) begin
			case (idx)
				fca_pkg::REG_AGE:   age_interval <= pwdata[39:0];
				fca_pkg::REG_SYN:   syn_age <= pwdata[39:0];
				fca_pkg::REG_SHORT: del_short <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			fca_pkg::REG_AGE:   prdata = {24'd0, age_interval};
			fca_pkg::REG_SYN:   prdata = {24'd0, syn_age};
			fca_pkg::REG_SHORT: prdata = {63'd0, del_short};
			default:            prdata = '0;
		endcase
	end
endmodule
`default_nettype wire

// ----- rtl/flow_counter_update_and_aging.sv -----
// Top level of the flow counter update and aging block.
`timescale 1ns / 1ps
`default_nettype none
`include "flow_counter_update_and_aging_defines.svh"
// Per-flow statistics table: add, scan and teardown items update one entry
// and return one result each. An item goes through the back-end states idle,
// memory read, update and write, and result, where it waits for m_tready;
// the two-entry queue lets the input side keep accepting while a result
// waits to be taken. The configuration port is 64 bits wide with the 40-bit
// registers at byte addresses 0 and 8 and the one-bit flag at 16.
module flow_counter_update_and_aging #(
	parameter int FLOW_ENTRIES = 4096
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// func, flow_index, kernel_valid, evict_marked, kernel_bytes,
	// kernel_packets, is_tcp, tcp_closed, tcp_syn, tcp_established,
	// short_flow, now_usec, zero pad
	input  wire logic [175:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// action, byte delta, packet delta, byte total, packet total,
	// first_export, tcp_aged, zero pad
	output logic [223:0]      m_tdata,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [4:0]   paddr,
	input  wire logic [63:0]  pwdata,
	output logic [63:0]       prdata,
	output logic              pready
);
	logic          q_valid, q_ready;
	fca_pkg::cmd_t q_cmd;
	fca_pkg::res_t res;
	logic [39:0]   age_interval, syn_age;
	logic          del_short;

	assign pready = 1'b1;

	fca_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
		.age_interval, .syn_age, .del_short
	);

	fca_front #(.FLOW_ENTRIES(FLOW_ENTRIES)) u_front (
		.clk, .arst_n, .in_valid(s_tvalid), .in_ready(s_tready),
		.in_data(s_tdata[172:0]),
		.q_valid, .q_ready, .q_cmd
	);

	fca_back #(.FLOW_ENTRIES(FLOW_ENTRIES)) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_cmd, .age_interval, .syn_age,
		.del_short, .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
	);

	assign m_tdata = {1'b0, res.tcp_aged, res.first_export, res.pkt_sum,
		res.byte_sum, res.pkt_delta, res.byte_delta, res.action};

	`FCA_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`FCA_ASSERT_IMP(a_no_overlap, clk, arst_n, m_tvalid, !q_ready)
	`FCA_ASSERT_IMP(a_action_range, clk, arst_n, m_tvalid, m_tdata[2:0] <= 3'd4)
endmodule
`default_nettype wire

// ----- tb/sv/tb_flow_counter_update_and_aging.sv -----
// Self-checking testbench for the flow counter update and aging block.
`timescale 1ns / 1ps
`default_nettype none
module tb_flow_counter_update_and_aging;
	typedef struct {
		fca_pkg::func_t func;
		logic [11:0] idx;
		logic        kv;
		logic        ev;
		logic [47:0] kb;
		logic [39:0] kp;
		logic        tcp;
		logic        closed;
		logic        syn;
		logic        est;
		logic        shrt;
		logic [63:0] now;
	} flow_item_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	// func, flow_index, kernel_valid, evict_marked, kernel_bytes, kernel_packets,
	// is_tcp, tcp_closed, tcp_syn, tcp_established, short_flow, now_usec, zero pad
	logic [175:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	// action, byte delta, packet delta, byte total, packet total,
	// first_export, tcp_aged, zero pad
	logic [223:0] m_tdata;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [4:0]   paddr = '0;
	logic [63:0]  pwdata = '0;
	logic [63:0]  prdata;
	logic         pready;

	flow_counter_update_and_aging dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #1 clk = ~clk;

	// flow table copy kept by the predictor
	logic [63:0] byte_tot [4096];
	logic [63:0] pkt_tot [4096];
	logic [63:0] change_t [4096];
	logic [63:0] setup_t [4096];
	logic        exported [4096];
	logic        torn [4096];
	logic [39:0] age_usec = fca_pkg::AGE_RESET;
	logic [39:0] syn_usec = fca_pkg::SYN_RESET;
	logic        del_short = 1'b0;

	fca_pkg::res_t expected_results [$];
	logic [11:0] live_flows [$];
	logic [63:0] clock_usec = 64'd1000;
	bit          idling = 1'b1;
	int          err_count = 0;
	int          item_count = 0;
	int          result_count = 0;
	int          stall_left = 0;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		err_count++;
	endtask

	function automatic void absorb_counters(input int e, input logic [47:0] kb,
			input logic [39:0] kp, output logic [63:0] db, output logic [63:0] dp);
		logic [63:0] nb;
		logic [63:0] np;
		nb = {byte_tot[e][63:48] + (byte_tot[e][47:0] > kb ? 16'd1 : 16'd0), kb};
		np = {pkt_tot[e][63:40] + (pkt_tot[e][39:0] > kp ? 24'd1 : 24'd0), kp};
		db = nb - byte_tot[e];
		dp = np - pkt_tot[e];
		byte_tot[e] = nb;
		pkt_tot[e] = np;
	endfunction

	function automatic fca_pkg::res_t predict_flow(input flow_item_t it);
		fca_pkg::res_t r;
		int          e;
		logic        deleted;
		logic        fresh;
		logic [63:0] db;
		logic [63:0] dp;
		r = '0;
		e = it.idx;
		db = '0;
		dp = '0;
		if (it.func == fca_pkg::FUNC_ADD) begin
			byte_tot[e] = '0;
			pkt_tot[e] = '0;
			setup_t[e] = it.now;
			change_t[e] = it.now;
			exported[e] = 1'b0;
			torn[e] = 1'b0;
			return r;
		end
		if (it.func == fca_pkg::FUNC_SCAN && !torn[e]) begin
			deleted = 1'b0;
			if (it.kv && it.tcp) begin
				if (it.closed)
					r.tcp_aged = 1'b1;
				else if (it.syn && !it.est && it.now - setup_t[e] >= {24'd0, syn_usec})
					r.tcp_aged = 1'b1;
			end
			if (it.kv && it.ev) begin
				deleted = 1'b1;
				r.action = fca_pkg::ACT_DEL_EVICT;
			end else begin
				fresh = it.kv && (byte_tot[e][47:0] < it.kb);
				if (!fresh && it.now - change_t[e] >= {24'd0, age_usec}) begin
					deleted = 1'b1;
					r.action = fca_pkg::ACT_DEL_AGED;
				end
			end
			if (!deleted && it.kv) begin
				if (byte_tot[e][47:0] != it.kb) begin
					absorb_counters(e, it.kb, it.kp, db, dp);
					change_t[e] = it.now;
					r.first_export = !exported[e];
					exported[e] = 1'b1;
					r.action = fca_pkg::ACT_EXPORT;
				end else if (!exported[e]) begin
					r.first_export = 1'b1;
					exported[e] = 1'b1;
					r.action = fca_pkg::ACT_EXPORT;
				end
			end
			if (!deleted && del_short && it.shrt)
				r.action = fca_pkg::ACT_DEL_SHORT;
		end else if (it.func == fca_pkg::FUNC_TEARDOWN && !torn[e]) begin
			if (it.kv)
				absorb_counters(e, it.kb, it.kp, db, dp);
			r.first_export = !exported[e];
			exported[e] = 1'b0;
			torn[e] = 1'b1;
			r.action = fca_pkg::ACT_EXPORT;
		end
		r.byte_delta = db[48:0];
		r.pkt_delta = dp[40:0];
		r.byte_sum = byte_tot[e];
		r.pkt_sum = pkt_tot[e];
		return r;
	endfunction

	task automatic send_item(input flow_item_t it);
		if (idling && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b0, it.now, it.shrt, it.est, it.syn, it.closed, it.tcp,
			it.kp, it.kb, it.ev, it.kv, it.idx, it.func};
		do @(posedge clk); while (!s_tready);
		expected_results.push_back(predict_flow(it));
		item_count++;
	endtask

	always @(posedge clk) begin
		fca_pkg::res_t got;
		fca_pkg::res_t want;
		if (m_tvalid && m_tready) begin
			got.action = m_tdata[2:0];
			got.byte_delta = m_tdata[51:3];
			got.pkt_delta = m_tdata[92:52];
			got.byte_sum = m_tdata[156:93];
			got.pkt_sum = m_tdata[220:157];
			got.first_export = m_tdata[221];
			got.tcp_aged = m_tdata[222];
			result_count++;
			if (expected_results.size() == 0) begin
				report_mismatch("result with no item outstanding");
			end else begin
				want = expected_results.pop_front();
				if (got.action != want.action)
					report_mismatch($sformatf("action %0d, want %0d", got.action, want.action));
				if (got.byte_delta != want.byte_delta)
					report_mismatch($sformatf("byte delta %h, want %h",
						got.byte_delta, want.byte_delta));
				if (got.pkt_delta != want.pkt_delta)
					report_mismatch($sformatf("packet delta %h, want %h",
						got.pkt_delta, want.pkt_delta));
				if (got.byte_sum != want.byte_sum)
					report_mismatch($sformatf("byte total %h, want %h",
						got.byte_sum, want.byte_sum));
				if (got.pkt_sum != want.pkt_sum)
					report_mismatch($sformatf("packet total %h, want %h",
						got.pkt_sum, want.pkt_sum));
				if (got.first_export != want.first_export)
					report_mismatch($sformatf("first_export %b, want %b",
						got.first_export, want.first_export));
				if (got.tcp_aged != want.tcp_aged)
					report_mismatch($sformatf("tcp_aged %b, want %b",
						got.tcp_aged, want.tcp_aged));
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (idling && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 10);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] reg_idx, input logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (reg_idx)
			fca_pkg::REG_AGE: age_usec = value[39:0];
			fca_pkg::REG_SYN: syn_usec = value[39:0];
			default: del_short = value[0];
		endcase
	endtask

	task automatic configure(input logic [39:0] age, input logic [39:0] syn, input logic shrt);
		wait_drained();
		write_reg(fca_pkg::REG_AGE, {24'd0, age});
		write_reg(fca_pkg::REG_SYN, {24'd0, syn});
		write_reg(fca_pkg::REG_SHORT, {63'd0, shrt});
	endtask

	function automatic flow_item_t make_item(input fca_pkg::func_t f, input logic [11:0] idx);
		flow_item_t it;
		it.func = f;
		it.idx = idx;
		it.kv = 1'b1;
		it.ev = 1'b0;
		if (f == fca_pkg::FUNC_ADD) begin
			it.kb = '0;
			it.kp = '0;
		end else begin
			it.kb = byte_tot[idx][47:0];
			it.kp = pkt_tot[idx][39:0];
		end
		it.tcp = 1'b0;
		it.closed = 1'b0;
		it.syn = 1'b0;
		it.est = 1'b0;
		it.shrt = 1'b0;
		it.now = clock_usec;
		return it;
	endfunction

	task automatic test_directed();
		flow_item_t it;
		send_item(make_item(fca_pkg::FUNC_ADD, 12'd0));
		send_item(make_item(fca_pkg::FUNC_ADD, 12'hfff));
		send_item(make_item(fca_pkg::FUNC_SCAN, 12'd0));
		it = make_item(fca_pkg::FUNC_SCAN, 12'd0);
		it.kb = 48'd100;
		it.kp = 40'd3;
		send_item(it);
		it = make_item(fca_pkg::FUNC_SCAN, 12'hfff);
		it.kb = '1;
		it.kp = '1;
		send_item(it);
		it = make_item(fca_pkg::FUNC_SCAN, 12'hfff);
		it.kb = 48'd5;
		it.kp = 40'd1;
		send_item(it);
		it = make_item(fca_pkg::FUNC_SCAN, 12'd0);
		it.tcp = 1'b1;
		it.closed = 1'b1;
		send_item(it);
		clock_usec = clock_usec + 64'd20000000;
		it = make_item(fca_pkg::FUNC_SCAN, 12'd0);
		it.kb = 48'd200;
		it.tcp = 1'b1;
		it.syn = 1'b1;
		send_item(it);
		it = make_item(fca_pkg::FUNC_SCAN, 12'd0);
		it.kv = 1'b0;
		it.ev = 1'b1;
		send_item(it);
		it = make_item(fca_pkg::FUNC_SCAN, 12'd0);
		it.ev = 1'b1;
		send_item(it);
		it = make_item(fca_pkg::FUNC_SCAN, 12'hfff);
		it.kv = 1'b0;
		it.now = 64'hffff_ffff_ffff_ffff;
		send_item(it);
		it = make_item(fca_pkg::FUNC_TEARDOWN, 12'd0);
		it.kb = 48'd300;
		it.kp = 40'd9;
		send_item(it);
		send_item(make_item(fca_pkg::FUNC_TEARDOWN, 12'd0));
		send_item(make_item(fca_pkg::FUNC_SCAN, 12'd0));
		it = make_item(fca_pkg::FUNC_TEARDOWN, 12'hfff);
		it.kv = 1'b0;
		send_item(it);
		send_item(make_item(fca_pkg::FUNC_BAD, 12'hfff));
		send_item(make_item(fca_pkg::FUNC_ADD, 12'd0));
		send_item(make_item(fca_pkg::FUNC_BAD, 12'd0));
		live_flows.push_back(12'd0);
		live_flows.push_back(12'hfff);
	endtask

	task automatic test_short_flow();
		flow_item_t it;
		configure(40'hff_ffff_ffff, 40'd0, 1'b1);
		send_item(make_item(fca_pkg::FUNC_ADD, 12'd7));
		it = make_item(fca_pkg::FUNC_SCAN, 12'd7);
		it.shrt = 1'b1;
		it.kb = 48'd64;
		it.tcp = 1'b1;
		it.syn = 1'b1;
		send_item(it);
		it = make_item(fca_pkg::FUNC_SCAN, 12'd7);
		it.shrt = 1'b1;
		it.est = 1'b1;
		send_item(it);
		live_flows.push_back(12'd7);
	endtask

	task automatic test_random(input int count);
		flow_item_t it;
		int         sel;
		logic [11:0] idx;
		for (int n = 0; n < count; n++) begin
			sel = $urandom_range(0, 99);
			if ($urandom_range(0, 32) == 0)
				clock_usec = {$urandom, $urandom};
			else
				clock_usec = clock_usec + $urandom_range(0, 30);
			if (sel < 10) begin
				if (live_flows.size() < 48 && $urandom_range(0, 2) == 0) begin
					idx = $urandom_range(0, 4095);
					live_flows.push_back(idx);
				end else begin
					idx = live_flows[$urandom_range(0, live_flows.size() - 1)];
				end
				it = make_item(fca_pkg::FUNC_ADD, idx);
			end else begin
				idx = live_flows[$urandom_range(0, live_flows.size() - 1)];
				it = make_item(sel < 80 ? fca_pkg::FUNC_SCAN :
					sel < 95 ? fca_pkg::FUNC_TEARDOWN : fca_pkg::FUNC_BAD, idx);
			end
			sel = $urandom_range(0, 99);
			if (sel < 50) begin
				it.kb = it.kb + $urandom_range(1, 2000);
				it.kp = it.kp + $urandom_range(0, 20);
			end else if (sel < 65) begin
				it.kp = it.kp + $urandom_range(0, 2);
			end else if (sel < 80) begin
				it.kb = it.kb - $urandom_range(1, 500);
				it.kp = it.kp - $urandom_range(0, 5);
			end else begin
				it.kb = {$urandom, $urandom};
				it.kp = {$urandom, $urandom};
			end
			it.kv = $urandom_range(0, 7) != 0;
			it.ev = $urandom_range(0, 11) == 0;
			it.tcp = $urandom_range(0, 1);
			it.closed = $urandom_range(0, 4) == 0;
			it.syn = $urandom_range(0, 1);
			it.est = $urandom_range(0, 1);
			it.shrt = $urandom_range(0, 3) == 0;
			send_item(it);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_short_flow();
		test_random(250);
		configure(40'd40, 40'd25, 1'b0);
		test_random(200);
		wait_drained();
		test_random(200);
		configure(40'd0, 40'hff_ffff_ffff, 1'b1);
		test_random(200);
		configure(40'd1000, 40'd300, 1'b1);
		idling = 1'b0;
		test_random(480);
		wait_drained();
		repeat (20) @(posedge clk);
		$display("Sent %0d items (add, scan, teardown, bad selector) and checked %0d results",
			item_count, result_count);
		$display("under five register settings with random back-pressure and idle gaps");
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#2000000;
		$display("Timeout with %0d results outstanding", expected_results.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+rtl
rtl/fca_pkg.sv
rtl/fca_front.sv
rtl/fca_back.sv
rtl/fca_regs.sv
rtl/flow_counter_update_and_aging.sv
tb/sv/tb_flow_counter_update_and_aging.sv
